// ----- sv/tvm_pkg.sv -----
package tvm_pkg;

    localparam int CfgIdxBits = 3;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_MAJOR_RADIUS = 3'd0,
        CFG_MINOR_RADIUS = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_CENTER_Z     = 3'd4
    } t_cfg_idx;

endpackage

// ----- sv/tvm_delta.sv -----
module tvm_delta #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_vld,
    input  logic [COORD_BITS-1:0]                   i_voxel_x,
    input  logic [COORD_BITS-1:0]                   i_voxel_y,
    input  logic [COORD_BITS-1:0]                   i_voxel_z,
    input  logic [COORD_BITS+FRAC_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS+FRAC_BITS-1:0]         i_center_y,
    input  logic [COORD_BITS+FRAC_BITS-1:0]         i_center_z,
    output logic                                    o_vld,
    output logic [2*(COORD_BITS+FRAC_BITS):0]       o_sum,
    output logic [2*(COORD_BITS+FRAC_BITS)-1:0]     o_dz2
);
    localparam int RegBits = COORD_BITS + FRAC_BITS;
    localparam int SqBits  = 2 * RegBits;
    localparam int SumBits = SqBits + 1;

    function automatic logic [RegBits-1:0] abs_diff(
        input logic [RegBits-1:0] a,
        input logic [RegBits-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [RegBits-1:0] w_px, w_py, w_pz;
    logic               r_vld_a, r_vld_b, r_vld_c;
    logic [RegBits-1:0] r_dx, r_dy, r_dz;
    logic [SqBits-1:0]  r_dx2, r_dy2, r_dz2_b, r_dz2_c;
    logic [SumBits-1:0] r_sum;

    // voxel index aligned to the fixed point grid
    assign w_px = RegBits'(i_voxel_x) << FRAC_BITS;
    assign w_py = RegBits'(i_voxel_y) << FRAC_BITS;
    assign w_pz = RegBits'(i_voxel_z) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= abs_diff(i_center_x, w_px);
        r_dy    <= abs_diff(i_center_y, w_py);
        r_dz    <= abs_diff(i_center_z, w_pz);
        r_dx2   <= SqBits'(r_dx) * SqBits'(r_dx);
        r_dy2   <= SqBits'(r_dy) * SqBits'(r_dy);
        r_dz2_b <= SqBits'(r_dz) * SqBits'(r_dz);
        r_sum   <= SumBits'(r_dx2) + SumBits'(r_dy2);
        r_dz2_c <= r_dz2_b;
    end

    assign o_vld = r_vld_c;
    assign o_sum = r_sum;
    assign o_dz2 = r_dz2_c;

endmodule

// ----- sv/tvm_isqrt.sv -----
module tvm_isqrt #(
    parameter int IN_BITS   = 29,
    parameter int SIDE_BITS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [IN_BITS-1:0]         i_value,
    input  logic [SIDE_BITS-1:0]       i_side,
    output logic                       o_vld,
    output logic [(IN_BITS+1)/2-1:0]   o_root,
    output logic [IN_BITS-1:0]         o_rem,
    output logic [SIDE_BITS-1:0]       o_side
);
    localparam int RootBits = (IN_BITS + 1) / 2;
    localparam int TrialBits = 2 * RootBits + 2;

    logic                 r_vld  [RootBits+1];
    logic [RootBits-1:0]  r_root [RootBits+1];
    logic [IN_BITS-1:0]   r_rem  [RootBits+1];
    logic [SIDE_BITS-1:0] r_side [RootBits+1];

    assign r_vld[0]  = i_vld;
    assign r_root[0] = '0;
    assign r_rem[0]  = i_value;
    assign r_side[0] = i_side;

    // one root bit per stage, msb first; rem holds value - root^2
    for (genvar k = 0; k < RootBits; k++) begin : g_stage
        localparam int Bit = RootBits - 1 - k;

        logic [TrialBits-1:0] w_trial;
        logic [TrialBits-1:0] w_rem_ext;
        logic                 w_take;

        // (root + 2^b)^2 - root^2
        assign w_trial   = (TrialBits'(r_root[k]) << (Bit + 1))
                         + (TrialBits'(1) << (2 * Bit));
        assign w_rem_ext = TrialBits'(r_rem[k]);
        assign w_take    = (w_rem_ext >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
            if (w_take) begin
                r_rem[k+1]  <= IN_BITS'(w_rem_ext - w_trial);
                r_root[k+1] <= r_root[k] | (RootBits'(1) << Bit);
            end else begin
                r_rem[k+1]  <= r_rem[k];
                r_root[k+1] <= r_root[k];
            end
        end
    end

    assign o_vld  = r_vld[RootBits];
    assign o_root = r_root[RootBits];
    assign o_rem  = r_rem[RootBits];
    assign o_side = r_side[RootBits];

endmodule

// ----- sv/tvm_tail.sv -----
module tvm_tail #(
    parameter int REG_BITS  = 14,
    parameter int ROOT_BITS = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [ROOT_BITS-1:0]     i_dist,
    input  logic [2*REG_BITS-1:0]    i_dz2,
    input  logic [REG_BITS-1:0]      i_major_radius,
    input  logic [REG_BITS-1:0]      i_minor_radius,
    output logic                     o_vld,
    output logic                     o_inside_res
);
    localparam int SqBits  = 2 * REG_BITS;
    localparam int TSqBits = 2 * ROOT_BITS;
    localparam int LhsBits = TSqBits + 1;

    logic [ROOT_BITS-1:0] w_major;
    logic                 r_vld_a, r_vld_b, r_vld_c;
    logic [ROOT_BITS-1:0] r_t;
    logic [SqBits-1:0]    r_dz2_a, r_dz2_b;
    logic [TSqBits-1:0]   r_t2;
    logic [SqBits-1:0]    r_rhs;
    logic                 r_inside;
    logic [LhsBits-1:0]   w_lhs;

    assign w_major = ROOT_BITS'(i_major_radius);
    assign w_lhs   = LhsBits'(r_t2) + LhsBits'(r_dz2_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        // signed offset from the tube center circle, only its magnitude matters
        r_t      <= (w_major >= i_dist) ? (w_major - i_dist) : (i_dist - w_major);
        r_dz2_a  <= i_dz2;
        r_t2     <= TSqBits'(r_t) * TSqBits'(r_t);
        r_dz2_b  <= r_dz2_a;
        r_rhs    <= SqBits'(i_minor_radius) * SqBits'(i_minor_radius);
        r_inside <= (w_lhs <= LhsBits'(r_rhs));
    end

    assign o_vld        = r_vld_c;
    assign o_inside_res = r_inside;

endmodule

// ----- sv/torus_voxel_membership_test.sv -----
// path: an accepted item passes the delta registers, one root stage per root bit, then the tail
// registers before its strobe on o_valid
// throughput: one item per cycle; busy is high in reset and the cycle after it, then low
// reset: synchronous active low; clears radii, center and all pipeline valid bits
// the receiver cannot stall: every result is shown for exactly one cycle on o_valid
module torus_voxel_membership_test #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             i_voxel_x,
    input  logic [COORD_BITS-1:0]             i_voxel_y,
    input  logic [COORD_BITS-1:0]             i_voxel_z,
    output logic                              o_valid,
    output logic                              o_inside_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tvm_pkg::CfgIdxBits-1:0]    i_cfg_index,
    input  logic [COORD_BITS+FRAC_BITS-1:0]   i_cfg_data
);
    import tvm_pkg::*;

    localparam int RegBits  = COORD_BITS + FRAC_BITS;
    localparam int SqBits   = 2 * RegBits;
    localparam int SumBits  = SqBits + 1;
    localparam int RootBits = (SumBits + 1) / 2;

    logic               r_busy;
    logic [RegBits-1:0] r_major_radius, r_minor_radius;
    logic [RegBits-1:0] r_center_x, r_center_y, r_center_z;
    logic               w_accept;
    logic               w_cfg_we;

    logic                d_vld;
    logic [SumBits-1:0]  d_sum;
    logic [SqBits-1:0]   d_dz2;
    logic                s_vld;
    logic [RootBits-1:0] s_root;
    logic [SumBits-1:0]  s_rem;
    logic [SqBits-1:0]   s_dz2;

    assign w_accept    = start && !r_busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b1;
            r_major_radius <= '0;
            r_minor_radius <= '0;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_center_z     <= '0;
        end else begin
            r_busy <= 1'b0;
            if (w_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MAJOR_RADIUS: r_major_radius <= i_cfg_data;
                    CFG_MINOR_RADIUS: r_minor_radius <= i_cfg_data;
                    CFG_CENTER_X:     r_center_x     <= i_cfg_data;
                    CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                    CFG_CENTER_Z:     r_center_z     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    tvm_delta #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_delta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_accept),
        .i_voxel_x  (i_voxel_x),
        .i_voxel_y  (i_voxel_y),
        .i_voxel_z  (i_voxel_z),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .o_vld      (d_vld),
        .o_sum      (d_sum),
        .o_dz2      (d_dz2)
    );

    tvm_isqrt #(
        .IN_BITS   (SumBits),
        .SIDE_BITS (SqBits)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_value (d_sum),
        .i_side  (d_dz2),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_rem   (s_rem),
        .o_side  (s_dz2)
    );

    tvm_tail #(
        .REG_BITS  (RegBits),
        .ROOT_BITS (RootBits)
    ) u_tail (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (s_vld),
        .i_dist         (s_root),
        .i_dz2          (s_dz2),
        .i_major_radius (r_major_radius),
        .i_minor_radius (r_minor_radius),
        .o_vld          (o_valid),
        .o_inside_res   (o_inside_res)
    );

`ifndef SYNTH
    // floor root: what is left over never exceeds twice the root
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_vld |-> ((SumBits + 1)'(s_rem) <= ((SumBits + 1)'(s_root) << 1)))
        else $error("root stage remainder out of range");

    a_strobe_follows_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(s_vld, 3))
        else $error("result strobe without a matching root beat");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && busy))
        else $error("pipeline not cleared by reset");
`endif

endmodule

// ----- tb/sv/torus_voxel_membership_test_tb.sv -----
`timescale 1ns / 1ps

module torus_voxel_membership_test_tb;

    import tvm_pkg::*;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 4;
    localparam int REG_BITS     = COORD_BITS + FRAC_BITS;
    localparam int VOX_MAX      = (1 << COORD_BITS) - 1;
    localparam int REG_MAX      = (1 << REG_BITS) - 1;
    localparam int PIPE_LATENCY = COORD_BITS + FRAC_BITS + 7;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [COORD_BITS-1:0] VOX_ONES = COORD_BITS'(VOX_MAX);
    localparam logic [REG_BITS-1:0]   REG_ONES = REG_BITS'(REG_MAX);

    localparam logic [CfgIdxBits-1:0] CFG_IDX_FIRST_UNUSED = CfgIdxBits'(CFG_CENTER_Z + 1);
    localparam logic [CfgIdxBits-1:0] CFG_IDX_TOP = CfgIdxBits'((1 << CfgIdxBits) - 1);

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  in_torus;
    } t_voxel_verdict;

    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic [COORD_BITS-1:0]   i_voxel_x    = '0;
    logic [COORD_BITS-1:0]   i_voxel_y    = '0;
    logic [COORD_BITS-1:0]   i_voxel_z    = '0;
    logic                    o_valid;
    logic                    o_inside_res;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CfgIdxBits-1:0]   i_cfg_index  = '0;
    logic [REG_BITS-1:0]     i_cfg_data   = '0;

    // torus geometry as the block should hold it
    logic [REG_BITS-1:0]     torus_c  = '0;
    logic [REG_BITS-1:0]     torus_a  = '0;
    logic [REG_BITS-1:0]     torus_cx = '0;
    logic [REG_BITS-1:0]     torus_cy = '0;
    logic [REG_BITS-1:0]     torus_cz = '0;

    t_voxel_verdict          inside_expect_q[$];
    int                      mismatch_count = 0;
    int                      cycle_count    = 0;

    torus_voxel_membership_test #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_voxel_x    (i_voxel_x),
        .i_voxel_y    (i_voxel_y),
        .i_voxel_z    (i_voxel_z),
        .o_valid      (o_valid),
        .o_inside_res (o_inside_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("torus_voxel_membership_test_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] dist_abs(input logic [63:0] p, input logic [63:0] q);
        return (p >= q) ? p - q : q - p;
    endfunction

    // largest r with r*r <= v, one bit at a time from the top
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic logic voxel_in_torus(input logic [COORD_BITS-1:0] vx,
                                            input logic [COORD_BITS-1:0] vy,
                                            input logic [COORD_BITS-1:0] vz);
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dz;
        logic [63:0] tube_off;
        dx = dist_abs(64'(torus_cx), 64'(vx) << FRAC_BITS);
        dy = dist_abs(64'(torus_cy), 64'(vy) << FRAC_BITS);
        dz = dist_abs(64'(torus_cz), 64'(vz) << FRAC_BITS);
        tube_off = dist_abs(64'(torus_c), root_floor(dx * dx + dy * dy));
        return (tube_off * tube_off + dz * dz) <= (64'(torus_a) * 64'(torus_a));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_voxel_verdict exp_v;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (inside_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %b with no voxel pending", o_inside_res));
            end else begin
                exp_v = inside_expect_q.pop_front();
                if (o_valid !== 1'b1 || o_inside_res !== exp_v.in_torus) begin
                    report_mismatch($sformatf("voxel (%0d,%0d,%0d) inside exp %b got %b valid %b",
                        exp_v.x, exp_v.y, exp_v.z, exp_v.in_torus, o_inside_res, o_valid));
                end
            end
        end
    end

    // leaves valid high unless it picks a random gap, so back-to-back writes need no drop
    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [REG_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_MAJOR_RADIUS: torus_c  = val;
            CFG_MINOR_RADIUS: torus_a  = val;
            CFG_CENTER_X:     torus_cx = val;
            CFG_CENTER_Y:     torus_cy = val;
            CFG_CENTER_Z:     torus_cz = val;
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic apply_torus(input logic [REG_BITS-1:0] c, input logic [REG_BITS-1:0] a,
                               input logic [REG_BITS-1:0] cx, input logic [REG_BITS-1:0] cy,
                               input logic [REG_BITS-1:0] cz);
        write_reg(CFG_MAJOR_RADIUS, c);
        write_reg(CFG_MINOR_RADIUS, a);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        i_cfg_valid <= 1'b0;
    endtask

    // start stays high after the beat; a gap or stop_voxels drops it
    task automatic send_voxel(input logic [COORD_BITS-1:0] vx, input logic [COORD_BITS-1:0] vy,
                              input logic [COORD_BITS-1:0] vz);
        t_voxel_verdict v;
        start     <= 1'b1;
        i_voxel_x <= vx;
        i_voxel_y <= vy;
        i_voxel_z <= vz;
        do @(posedge i_clk); while (busy !== 1'b0);
        v.x = vx;
        v.y = vy;
        v.z = vz;
        v.in_torus = voxel_in_torus(vx, vy, vz);
        inside_expect_q.push_back(v);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic stop_voxels();
        start <= 1'b0;
        while (inside_expect_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] coord_near(input logic [REG_BITS-1:0] ctr,
                                                         input int span);
        int v;
        v = int'(ctr >> FRAC_BITS) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > VOX_MAX) v = VOX_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic test_reset_values();
        // all registers zero: only the origin voxel passes
        send_voxel(0, 0, 0);
        send_voxel(1, 0, 0);
        send_voxel(0, 0, 1);
        send_voxel(VOX_ONES, VOX_ONES, VOX_ONES);
        stop_voxels();
    endtask

    task automatic test_zero_radii();
        apply_torus(0, 0, 512 << FRAC_BITS, 300 << FRAC_BITS, 7 << FRAC_BITS);
        send_voxel(512, 300, 7);
        send_voxel(513, 300, 7);
        send_voxel(512, 300, 8);
        stop_voxels();
        // zero tube on a ring of radius 5: points exactly on the ring pass
        apply_torus(5 << FRAC_BITS, 0, 100 << FRAC_BITS, 100 << FRAC_BITS, 100 << FRAC_BITS);
        send_voxel(105, 100, 100);
        send_voxel(103, 104, 100);
        send_voxel(103, 104, 101);
        stop_voxels();
    endtask

    task automatic test_boundary();
        apply_torus(10 << FRAC_BITS, 3 << FRAC_BITS, 200 << FRAC_BITS, 200 << FRAC_BITS,
                    200 << FRAC_BITS);
        send_voxel(213, 200, 200);
        send_voxel(214, 200, 200);
        send_voxel(210, 200, 203);
        send_voxel(210, 200, 204);
        send_voxel(207, 200, 200);
        send_voxel(206, 200, 200);
        // planar distance just above 13, floored onto the outer rim
        send_voxel(213, 201, 200);
        stop_voxels();
    endtask

    task automatic test_field_extremes();
        apply_torus(REG_ONES, REG_ONES, REG_ONES, REG_ONES, REG_ONES);
        send_voxel(VOX_ONES, VOX_ONES, VOX_ONES);
        send_voxel(0, 0, 0);
        send_voxel(0, VOX_ONES, 0);
        send_voxel(VOX_ONES, 0, VOX_ONES);
        stop_voxels();
        apply_torus(0, REG_ONES, 0, 0, 0);
        send_voxel(VOX_ONES, VOX_ONES, VOX_ONES);
        send_voxel(0, 0, 0);
        stop_voxels();
    endtask

    task automatic test_unused_index();
        apply_torus(10 << FRAC_BITS, 3 << FRAC_BITS, 200 << FRAC_BITS, 200 << FRAC_BITS,
                    200 << FRAC_BITS);
        @(posedge i_clk);
        for (int idx = CFG_IDX_FIRST_UNUSED; idx <= CFG_IDX_TOP; idx++) begin
            write_reg(idx[CfgIdxBits-1:0], REG_BITS'($urandom_range(0, REG_MAX)));
        end
        i_cfg_valid <= 1'b0;
        send_voxel(213, 200, 200);
        send_voxel(214, 200, 200);
        send_voxel(200, 200, 200);
        stop_voxels();
    endtask

    task automatic run_volume_phase(input int phase, input int n_items, input int gap_pct);
        logic [REG_BITS-1:0] c;
        logic [REG_BITS-1:0] a;
        logic [REG_BITS-1:0] cx;
        logic [REG_BITS-1:0] cy;
        logic [REG_BITS-1:0] cz;
        int span_xy;
        int span_z;
        c  = REG_BITS'($urandom_range(0, 80 << FRAC_BITS));
        a  = REG_BITS'($urandom_range(0, 24 << FRAC_BITS));
        cx = REG_BITS'($urandom_range(0, REG_MAX));
        cy = REG_BITS'($urandom_range(0, REG_MAX));
        cz = REG_BITS'($urandom_range(0, REG_MAX));
        case (phase)
            0: begin
                c = REG_ONES;
                a = REG_ONES;
            end
            1: c = 0;
            2: begin
                cx = 0;
                cy = 0;
                cz = 0;
            end
            3: begin
                cx = REG_ONES;
                cy = REG_ONES;
                cz = REG_ONES;
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    c = REG_BITS'($urandom_range(0, REG_MAX));
                    a = REG_BITS'($urandom_range(0, REG_MAX));
                end
            end
        endcase
        apply_torus(c, a, cx, cy, cz);
        span_xy = ((int'(c) + int'(a)) >> FRAC_BITS) + 2;
        span_z  = (int'(a) >> FRAC_BITS) + 2;
        if (span_xy > VOX_MAX) span_xy = VOX_MAX;
        if (span_z > VOX_MAX) span_z = VOX_MAX;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_voxel(COORD_BITS'($urandom_range(0, VOX_MAX)),
                           COORD_BITS'($urandom_range(0, VOX_MAX)),
                           COORD_BITS'($urandom_range(0, VOX_MAX)));
            end else begin
                send_voxel(coord_near(cx, span_xy), coord_near(cy, span_xy),
                           coord_near(cz, span_z));
            end
            sender_gap(gap_pct);
        end
        stop_voxels();
    endtask

    task automatic test_random_volume();
        for (int k = 0; k < 10; k++) begin
            run_volume_phase(k, 120, (k % 3 == 1) ? 0 : $urandom_range(10, 60));
        end
    endtask

    task automatic test_back_to_back();
        for (int k = 0; k < 3; k++) begin
            run_volume_phase(10 + k, 50, 0);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_zero_radii();
        test_boundary();
        test_field_extremes();
        test_unused_index();
        test_random_volume();
        test_back_to_back();
        stop_voxels();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0 && inside_expect_q.size() == 0) begin
            $display("torus_voxel_membership_test_tb: PASS");
        end else begin
            $display("torus_voxel_membership_test_tb: FAIL");
        end
        $finish;
    end

endmodule
